// ----- rtl/core/lis_pkg.sv -----
// lis_pkg: sizes and word types shared by the lis length tracker files
// no dependencies

package lis_pkg;

   localparam int MAX_LEN     = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(MAX_LEN);
   localparam int CNT_W       = $clog2(MAX_LEN + 1);
   localparam int LEN_W       = 11;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic             done_res;
      logic             overflow;
   } rsp_type;

endpackage

// ----- rtl/core/lis_length_tracker.sv -----
// lis_length_tracker: longest strictly increasing subsequence length, patience method
// depends on lis_pkg

// Each request word carries a signed value; the block keeps the smallest tail per
// subsequence length in a 1024-entry tail memory (one synchronous read port, read
// data registered) and binary-searches it for the first tail >= value. An item passes
// through an accept step, one search step per memory read (none for an empty store)
// and a write/result step that waits while the result output is stalled. A word
// marked last closes the sequence: its result shows the final length, then the count
// and the sticky overflow clear. The next request is accepted once the result is in
// the output register.
module lis_length_tracker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lis_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lis_pkg::rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SRCH  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic signed [lis_pkg::VALUE_WIDTH-1:0] tail_mem [lis_pkg::MAX_LEN];
   logic signed [lis_pkg::VALUE_WIDTH-1:0] rd_data_ff;
   logic signed [lis_pkg::VALUE_WIDTH-1:0] key_ff, key_in;

   logic [1:0]               state_ff, state_in;
   logic [lis_pkg::CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [lis_pkg::CNT_W-1:0] count_ff, count_in;
   logic [lis_pkg::CNT_W:0]   mid_sum;
   logic                      ovf_ff, ovf_in;
   logic                      last_ff, last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lis_pkg::rsp_type          rsp_ff, rsp_in;

   logic                      accept, lt, fire, ins, app, mem_we;
   logic [lis_pkg::IDX_W-1:0] rd_addr, wr_addr;
   logic [lis_pkg::CNT_W-1:0] new_count;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign lt      = rd_data_ff < key_ff;
   assign fire    = !rsp_valid_ff || rsp_ready;
   assign ins     = lo_ff < count_ff;
   assign app     = !ins && (count_ff < lis_pkg::CNT_W'(lis_pkg::MAX_LEN));
   assign mem_we  = (state_ff == ST_WRITE) && fire && (ins || app);
   // insert and append both land at lo (lo equals count on append)
   assign wr_addr = lo_ff[lis_pkg::IDX_W-1:0];
   assign new_count = count_ff + lis_pkg::CNT_W'(app);

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in  = req_data.value[lis_pkg::VALUE_WIDTH-1:0];
               last_in = req_data.last;
               lo_in   = '0;
               hi_in   = count_ff;
               state_in = (count_ff == '0) ? ST_WRITE : ST_SRCH;
            end
         end
         ST_SRCH: begin
            // compare the tail read last cycle, then narrow the window
            if (lt) begin
               lo_in = mid_ff + lis_pkg::CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
            if (!(lo_in < hi_in)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (fire) begin
               rsp_valid_in    = 1'b1;
               rsp_in.length   = lis_pkg::LEN_W'(new_count);
               rsp_in.done_res = last_ff;
               rsp_in.overflow = ovf_ff || (!ins && !app);
               if (last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  count_in = new_count;
                  ovf_in   = rsp_in.overflow;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
      mid_in  = mid_sum[lis_pkg::CNT_W:1];
   end

   // mid is below count whenever the search uses its read; other reads are ignored
   assign rd_addr = mid_in[lis_pkg::IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tail_mem[wr_addr] <= key_ff;
      end
      rd_data_ff <= tail_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      last_ff <= last_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/lis_length_tracker_checker.sv -----
// lis_checker: port-level checks for lis_length_tracker, bound to each of its instances
// depends on lis_pkg and lis_length_tracker

module lis_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lis_pkg::rsp_type rsp_data
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // every result counts at least the value just taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.length != '0)
      else $error("result length is zero");

   // overflow only once the store is full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |->
         rsp_data.length == lis_pkg::LEN_W'(lis_pkg::MAX_LEN))
      else $error("overflow flagged below full length");

   // one word in flight: no accept on the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind lis_length_tracker lis_checker u_lis_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
